FILE: src/sfcmu_pkg.sv
// ----------------------------------------------------------------------------
// sfcmu_pkg
// Shared types, constants and the CRC-8 function for the encoder frame
// checker and multi-turn unwrapper.
// ----------------------------------------------------------------------------
package sfcmu_pkg;

    localparam int ANGLE_BITS_DEF = 21;
    localparam int FRAME_ANGLE_W  = 21;
    localparam int TOTAL_W        = 64;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [7:0] CRC_POLY = 8'h07;

    typedef enum logic [0:0] {
        REG_DIRECTION = 1'b0,
        REG_CRC_INIT  = 1'b1
    } reg_idx_t;

    typedef enum logic [0:0] {
        REQ_FRAME  = 1'b0,
        REQ_PRESET = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        CMD_FRAME  = 2'd0,
        CMD_BAD    = 2'd1,
        CMD_PRESET = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        logic                       req_type;
        logic [7:0]                 angle_high_byte;
        logic [7:0]                 angle_mid_byte;
        logic [7:0]                 angle_low_status_byte;
        logic [7:0]                 crc_byte;
        logic signed [TOTAL_W-1:0]  preset_value;
    } in_t;

    typedef struct packed {
        logic                       frame_status;
        logic [FRAME_ANGLE_W-1:0]   single_turn;
        logic signed [TOTAL_W-1:0]  multi_turn_total;
        logic                       overspeed_flag;
        logic                       weak_field_flag;
        logic                       under_voltage_flag;
    } out_t;

    typedef struct packed {
        cmd_kind_t                  kind;
        logic [FRAME_ANGLE_W-1:0]   angle;
        logic [2:0]                 status;
        logic signed [TOTAL_W-1:0]  preset_value;
    } cmd_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] r;
        r = crc ^ data;
        for (int b = 0; b < 8; b++)
        begin
            if (r[7])
                r = {r[6:0], 1'b0} ^ CRC_POLY;
            else
                r = {r[6:0], 1'b0};
        end
        return r;
    endfunction

endpackage

FILE: src/sfcmu_front.sv
// ----------------------------------------------------------------------------
// sfcmu_front
// Checks the frame CRC and classifies each request into a command for the
// back end: good frame, bad frame or preset.
// ----------------------------------------------------------------------------
module sfcmu_front (
    input  sfcmu_pkg::in_t  in_data,
    input  logic [7:0]      crc_initial,
    output sfcmu_pkg::cmd_t cmd
);

    logic [7:0] crc_a;
    logic [7:0] crc_b;
    logic [7:0] crc_c;

    always_comb
    begin
        crc_a = sfcmu_pkg::crc8_byte(crc_initial, in_data.angle_high_byte);
        crc_b = sfcmu_pkg::crc8_byte(crc_a, in_data.angle_mid_byte);
        crc_c = sfcmu_pkg::crc8_byte(crc_b, in_data.angle_low_status_byte);

        cmd.angle        = {in_data.angle_high_byte, in_data.angle_mid_byte,
                            in_data.angle_low_status_byte[7:3]};
        cmd.status       = in_data.angle_low_status_byte[2:0];
        cmd.preset_value = in_data.preset_value;

        if (in_data.req_type == sfcmu_pkg::REQ_PRESET)
            cmd.kind = sfcmu_pkg::CMD_PRESET;
        else if (crc_c != in_data.crc_byte)
            cmd.kind = sfcmu_pkg::CMD_BAD;
        else
            cmd.kind = sfcmu_pkg::CMD_FRAME;
    end

endmodule

FILE: src/sfcmu_queue.sv
// ----------------------------------------------------------------------------
// sfcmu_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module sfcmu_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sfcmu_pkg::cmd_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            valid,
    output sfcmu_pkg::cmd_t pop_data
);

    localparam int DEPTH = sfcmu_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sfcmu_pkg::cmd_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !valid))
        else $error("pop from empty queue");

endmodule

FILE: src/sfcmu_back.sv
// ----------------------------------------------------------------------------
// sfcmu_back
// Executes commands: unwraps the angle step, updates the multi-turn total and
// the latched flags, and holds the result in an output register.
// ----------------------------------------------------------------------------
module sfcmu_back #(
    parameter int ANGLE_BITS = sfcmu_pkg::ANGLE_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  sfcmu_pkg::cmd_t cmd,
    output logic            pop,
    input  logic            direction_inverted,
    output logic            out_valid,
    input  logic            out_ready,
    output sfcmu_pkg::out_t out_data
);

    localparam int TW = sfcmu_pkg::TOTAL_W;
    localparam int FW = sfcmu_pkg::FRAME_ANGLE_W;
    localparam logic signed [ANGLE_BITS:0] HALF_POS = {2'b01, {(ANGLE_BITS-1){1'b0}}};
    localparam logic signed [ANGLE_BITS:0] HALF_NEG = {2'b11, {(ANGLE_BITS-1){1'b0}}};
    localparam logic signed [ANGLE_BITS:0] FULL_PAT = {1'b1, {ANGLE_BITS{1'b0}}};

    logic [ANGLE_BITS-1:0]    prev_angle_reg;
    logic [ANGLE_BITS-1:0]    prev_angle_next;
    logic [ANGLE_BITS-1:0]    cur_angle_reg;
    logic [ANGLE_BITS-1:0]    cur_angle_next;
    logic signed [TW-1:0]     total_reg;
    logic signed [TW-1:0]     total_next;
    logic [2:0]               flags_reg;
    logic [2:0]               flags_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    sfcmu_pkg::out_t          out_data_reg;
    sfcmu_pkg::out_t          out_data_next;

    logic [ANGLE_BITS-1:0]    angle;
    logic signed [ANGLE_BITS:0] raw;
    logic signed [ANGLE_BITS:0] delta;
    logic signed [TW-1:0]     step;
    logic                     status;

    assign pop       = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        angle = cmd.angle[ANGLE_BITS-1:0];
        raw   = $signed({1'b0, angle}) - $signed({1'b0, prev_angle_reg});
        if (raw > HALF_POS || raw < HALF_NEG)
            delta = raw + FULL_PAT;
        else
            delta = raw;
        step = TW'(delta);

        prev_angle_next = prev_angle_reg;
        cur_angle_next  = cur_angle_reg;
        total_next      = total_reg;
        flags_next      = flags_reg;
        status          = 1'b0;

        unique case (cmd.kind)
            sfcmu_pkg::CMD_FRAME:
            begin
                prev_angle_next = angle;
                cur_angle_next  = angle;
                flags_next      = cmd.status;
                total_next      = direction_inverted ? total_reg - step : total_reg + step;
            end
            sfcmu_pkg::CMD_PRESET:
            begin
                total_next     = cmd.preset_value;
                cur_angle_next = cmd.preset_value[ANGLE_BITS-1:0];
            end
            sfcmu_pkg::CMD_BAD:
            begin
                status = 1'b1;
            end
            default:
            begin
                status = 1'b1;
            end
        endcase

        out_data_next.frame_status       = status;
        out_data_next.single_turn        = FW'(cur_angle_next);
        out_data_next.multi_turn_total   = total_next;
        out_data_next.overspeed_flag     = flags_next[0];
        out_data_next.weak_field_flag    = flags_next[1];
        out_data_next.under_voltage_flag = flags_next[2];

        if (pop)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_angle_reg <= '0;
            cur_angle_reg  <= '0;
            total_reg      <= '0;
            flags_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                prev_angle_reg <= prev_angle_next;
                cur_angle_reg  <= cur_angle_next;
                total_reg      <= total_next;
                flags_reg      <= flags_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            out_data_reg <= out_data_next;
    end

    a_bad_keeps_total: assert property (@(posedge clk) disable iff (!rst_n)
        pop && cmd.kind == sfcmu_pkg::CMD_BAD |=> $stable(total_reg) && $stable(cur_angle_reg))
        else $error("bad frame changed state");

    a_preset_loads: assert property (@(posedge clk) disable iff (!rst_n)
        pop && cmd.kind == sfcmu_pkg::CMD_PRESET |=> total_reg == $past(cmd.preset_value))
        else $error("preset not loaded");

    a_result_matches: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_data_reg.multi_turn_total == total_reg)
        else $error("result total differs from state");

endmodule

FILE: src/sensor_frame_check_multiturn_unwrap.sv
// ----------------------------------------------------------------------------
// sensor_frame_check_multiturn_unwrap
// Encoder frame CRC-8 check with multi-turn angle unwrap; top level with
// APB register port.
// ----------------------------------------------------------------------------
// Result path: an accepted input goes into the queue, then is popped into the
// back-end result register once it is free or read. Throughput: one item per
// cycle unless the output stalls, set by the combinational CRC and 64-bit add.
// Reset: asynchronous, clears the queue, the angle/total/flag state and both
// configuration registers; no clearing pass.
module sensor_frame_check_multiturn_unwrap #(
    parameter int ANGLE_BITS = sfcmu_pkg::ANGLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  sfcmu_pkg::in_t                    in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output sfcmu_pkg::out_t                   out_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sfcmu_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [sfcmu_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [sfcmu_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready
);

    logic                direction_reg;
    logic [7:0]          crc_init_reg;
    logic                wr_en;
    sfcmu_pkg::reg_idx_t reg_idx;

    sfcmu_pkg::cmd_t     front_cmd;
    sfcmu_pkg::cmd_t     q_cmd;
    logic                q_full;
    logic                q_valid;
    logic                q_pop;
    logic                q_push;

    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite && pready;
    assign reg_idx  = sfcmu_pkg::reg_idx_t'(paddr[2]);
    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;

    always_comb
    begin
        unique case (reg_idx)
            sfcmu_pkg::REG_DIRECTION: prdata = sfcmu_pkg::APB_DATA_W'(direction_reg);
            sfcmu_pkg::REG_CRC_INIT:  prdata = sfcmu_pkg::APB_DATA_W'(crc_init_reg);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 1'b0;
            crc_init_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                sfcmu_pkg::REG_DIRECTION: direction_reg <= pwdata[0];
                sfcmu_pkg::REG_CRC_INIT:  crc_init_reg  <= pwdata[7:0];
                default:                  direction_reg <= direction_reg;
            endcase
        end
    end

    sfcmu_front u_front (
        .in_data     (in_data),
        .crc_initial (crc_init_reg),
        .cmd         (front_cmd)
    );

    sfcmu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_cmd)
    );

    sfcmu_back #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .q_valid            (q_valid),
        .cmd                (q_cmd),
        .pop                (q_pop),
        .direction_inverted (direction_reg),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .out_data           (out_data)
    );

endmodule

FILE: test/sensor_frame_check_multiturn_unwrap_tb.sv
// ----------------------------------------------------------------------------
// sensor_frame_check_multiturn_unwrap_tb
// Self-checking bench for the encoder frame checker and multi-turn unwrapper.
// A tracker class predicts every result from the accepted input transfers:
// CRC-8 check, half-range angle unwrap, 64-bit wrapping total, presets and
// latched status flags. A directed opening is followed by random traffic under
// several register settings, with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module sensor_frame_check_multiturn_unwrap_tb;

    localparam int ANGLE_W = sfcmu_pkg::ANGLE_BITS_DEF;
    localparam longint HALF_STEP = longint'(1) << (ANGLE_W - 1);
    localparam longint FULL_STEP = longint'(1) << ANGLE_W;
    localparam logic [ANGLE_W-1:0] HALF_ANGLE = {1'b1, {(ANGLE_W-1){1'b0}}};
    localparam logic [ANGLE_W-1:0] MAX_ANGLE = '1;
    localparam logic [63:0] TOTAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] TOTAL_MIN = 64'h8000_0000_0000_0000;
    localparam int RANDOM_PER_SETTING = 208;
    localparam int TIMEOUT_CYCLES = 500000;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    sfcmu_pkg::in_t in_data;
    logic out_valid;
    logic out_ready;
    sfcmu_pkg::out_t out_data;
    logic psel;
    logic penable;
    logic pwrite;
    logic [sfcmu_pkg::APB_ADDR_W-1:0] paddr;
    logic [sfcmu_pkg::APB_DATA_W-1:0] pwdata;
    logic [sfcmu_pkg::APB_DATA_W-1:0] prdata;
    logic pready;

    bit hold_req;
    int holds_done;
    int settings_done;

    function automatic logic [7:0] frame_crc(input logic [7:0] seed, input logic [23:0] bits);
        logic [7:0] c;
        c = seed;
        for (int i = 23; i >= 0; i--)
        begin
            if (c[7] ^ bits[i])
                c = {c[6:0], 1'b0} ^ sfcmu_pkg::CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    class multiturn_tracker;
        bit                 dir_inverted;
        bit [7:0]           crc_seed;
        bit [ANGLE_W-1:0]   prev_angle;
        bit [ANGLE_W-1:0]   cur_angle;
        bit [63:0]          total;
        bit [2:0]           flags;
        sfcmu_pkg::out_t    expected_results[$];
        int                 mismatches;
        int                 frames_good;
        int                 frames_bad;
        int                 presets;
        int                 folds;
        int                 results_seen;

        function int pending();
            return expected_results.size();
        endfunction

        function void note_transfer(sfcmu_pkg::in_t item);
            sfcmu_pkg::out_t    res;
            logic [ANGLE_W-1:0] angle;
            longint             step;
            bit                 crc_bad;
            crc_bad = 1'b0;
            if (item.req_type == sfcmu_pkg::REQ_PRESET)
            begin
                total = item.preset_value;
                cur_angle = item.preset_value[ANGLE_W-1:0];
                presets++;
            end
            else if (frame_crc(crc_seed, {item.angle_high_byte, item.angle_mid_byte,
                                          item.angle_low_status_byte}) != item.crc_byte)
            begin
                crc_bad = 1'b1;
                frames_bad++;
            end
            else
            begin
                angle = {item.angle_high_byte, item.angle_mid_byte,
                         item.angle_low_status_byte[7:3]};
                flags = item.angle_low_status_byte[2:0];
                step = longint'(angle) - longint'(prev_angle);
                if (step > HALF_STEP)
                begin
                    step -= FULL_STEP;
                    folds++;
                end
                else if (step < -HALF_STEP)
                begin
                    step += FULL_STEP;
                    folds++;
                end
                total = dir_inverted ? total - step : total + step;
                prev_angle = angle;
                cur_angle = angle;
                frames_good++;
            end
            res.frame_status = crc_bad;
            res.single_turn = cur_angle;
            res.multi_turn_total = total;
            res.overspeed_flag = flags[0];
            res.weak_field_flag = flags[1];
            res.under_voltage_flag = flags[2];
            expected_results.push_back(res);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(sfcmu_pkg::out_t got);
            sfcmu_pkg::out_t want;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result transfer, expected none, actual %h",
                         $time, got);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("frame_status", want.frame_status, got.frame_status);
            compare_field("single_turn", want.single_turn, got.single_turn);
            compare_field("multi_turn_total", want.multi_turn_total, got.multi_turn_total);
            compare_field("overspeed_flag", want.overspeed_flag, got.overspeed_flag);
            compare_field("weak_field_flag", want.weak_field_flag, got.weak_field_flag);
            compare_field("under_voltage_flag", want.under_voltage_flag,
                          got.under_voltage_flag);
            results_seen++;
        endfunction
    endclass

    multiturn_tracker tracker;

    sensor_frame_check_multiturn_unwrap uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_result(out_data);
    end

    function automatic sfcmu_pkg::in_t build_frame(input logic [ANGLE_W-1:0] angle,
                                                   input logic [2:0] status,
                                                   input bit corrupt);
        sfcmu_pkg::in_t item;
        logic [7:0]     c;
        item.req_type = sfcmu_pkg::REQ_FRAME;
        item.angle_high_byte = angle[20:13];
        item.angle_mid_byte = angle[12:5];
        item.angle_low_status_byte = {angle[4:0], status};
        c = frame_crc(tracker.crc_seed, {item.angle_high_byte, item.angle_mid_byte,
                                         item.angle_low_status_byte});
        if (corrupt)
            c ^= 8'($urandom_range(1, 255));
        item.crc_byte = c;
        item.preset_value = {$urandom, $urandom};
        return item;
    endfunction

    function automatic sfcmu_pkg::in_t build_preset(input logic [63:0] value);
        sfcmu_pkg::in_t item;
        item.req_type = sfcmu_pkg::REQ_PRESET;
        item.angle_high_byte = 8'($urandom);
        item.angle_mid_byte = 8'($urandom);
        item.angle_low_status_byte = 8'($urandom);
        item.crc_byte = 8'($urandom);
        item.preset_value = value;
        return item;
    endfunction

    function automatic logic [ANGLE_W-1:0] next_angle();
        logic [ANGLE_W-1:0] p;
        p = tracker.prev_angle;
        case ($urandom_range(0, 6))
            0: return ANGLE_W'($urandom);
            1: return p + ANGLE_W'($urandom_range(0, 64)) - ANGLE_W'(32);
            2: return p + HALF_ANGLE;
            3: return p + HALF_ANGLE + ANGLE_W'(1);
            4: return p + HALF_ANGLE - ANGLE_W'(1);
            5: return $urandom_range(0, 1) ? MAX_ANGLE : '0;
            default: return p + ANGLE_W'($urandom_range(0, 1 << 19));
        endcase
    endfunction

    function automatic sfcmu_pkg::in_t next_item();
        int         pick;
        logic [63:0] value;
        pick = $urandom_range(0, 19);
        if (pick < 3)
        begin
            case ($urandom_range(0, 9))
                0: value = TOTAL_MAX;
                1: value = TOTAL_MIN;
                2: value = '0;
                3: value = '1;
                default: value = {$urandom, $urandom};
            endcase
            return build_preset(value);
        end
        else if (pick < 6)
            return build_frame(ANGLE_W'($urandom), 3'($urandom), 1'b1);
        return build_frame(next_angle(), 3'($urandom), 1'b0);
    endfunction

    task automatic send_item(input sfcmu_pkg::in_t item);
        in_valid = 1'b1;
        in_data = item;
        forever
        begin
            @(posedge clk);
            if (in_ready)
                break;
        end
        tracker.note_transfer(item);
        @(negedge clk);
    endtask

    task automatic reg_write(input sfcmu_pkg::reg_idx_t idx, input logic [31:0] value);
        logic [31:0] mask;
        mask = (idx == sfcmu_pkg::REG_DIRECTION) ? 32'h1 : 32'hFF;
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if ((prdata & mask) !== (value & mask))
        begin
            $display("%0t: register %0d readback mismatch, expected %h, actual %h",
                     $time, idx, value & mask, prdata & mask);
            tracker.mismatches++;
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        if (idx == sfcmu_pkg::REG_DIRECTION)
            tracker.dir_inverted = value[0];
        else
            tracker.crc_seed = value[7:0];
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_directed();
        send_item(build_frame('0, 3'd0, 1'b0));
        send_item(build_frame(MAX_ANGLE, 3'd7, 1'b0));
        send_item(build_frame('0, 3'd1, 1'b0));
        send_item(build_frame(HALF_ANGLE, 3'd2, 1'b0));
        send_item(build_frame('0, 3'd4, 1'b0));
        send_item(build_frame(HALF_ANGLE + ANGLE_W'(1), 3'd3, 1'b0));
        send_item(build_frame(HALF_ANGLE - ANGLE_W'(1), 3'd6, 1'b0));
        send_item(build_frame(21'h0A5A5A, 3'd5, 1'b1));
        send_item(build_frame(MAX_ANGLE, 3'd7, 1'b1));
        send_item(build_preset(TOTAL_MAX));
        send_item(build_frame(tracker.prev_angle + ANGLE_W'(1000), 3'd0, 1'b0));
        send_item(build_preset(TOTAL_MIN));
        send_item(build_frame(tracker.prev_angle - ANGLE_W'(1000), 3'd1, 1'b0));
        send_item(build_preset('0));
        send_item(build_preset('1));
        send_item(build_frame(tracker.prev_angle, 3'd0, 1'b0));
        send_item(build_preset(64'h0000_0000_0012_3456));
        send_item(build_frame(21'h15AAAA, 3'd7, 1'b1));
        in_valid = 1'b0;
    endtask

    task automatic run_traffic(input int count, input bit no_gaps);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 30);
            for (int k = 0; k < burst && sent < count; k++)
            begin
                send_item(next_item());
                sent++;
            end
            gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        in_valid = 1'b0;
    endtask

    initial
    begin
        int seg_len;
        int mode;
        int hold_left;
        out_ready = 1'b0;
        seg_len = 0;
        mode = 0;
        hold_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = 150;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready = 1'b0;
            end
            else
            begin
                if (seg_len == 0)
                begin
                    seg_len = $urandom_range(10, 120);
                    mode = $urandom_range(0, 2);
                end
                seg_len--;
                case (mode)
                    0: out_ready = 1'b1;
                    1: out_ready = 1'($urandom_range(0, 1));
                    default: out_ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin
        #(TIMEOUT_CYCLES * 8);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        bit       dir_list[6];
        bit [7:0] seed_list[6];
        tracker = new;
        dir_list = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        seed_list = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'($urandom), 8'($urandom)};
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_req = 1'b0;
        holds_done = 0;
        settings_done = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        reg_write(sfcmu_pkg::REG_DIRECTION, 32'd0);
        reg_write(sfcmu_pkg::REG_CRC_INIT, 32'd0);
        run_directed();
        wait_idle();

        for (int s = 0; s < 6; s++)
        begin
            reg_write(sfcmu_pkg::REG_DIRECTION, {31'd0, dir_list[s]});
            reg_write(sfcmu_pkg::REG_CRC_INIT, {24'd0, seed_list[s]});
            settings_done++;
            if (s == 2)
                hold_req = 1'b1;
            run_traffic(RANDOM_PER_SETTING, s == 2 || s == 4);
            wait_idle();
        end

        repeat (8) @(posedge clk);
        $display("Checked %0d results: %0d good frames (%0d folded), %0d CRC rejects, %0d presets",
                 tracker.results_seen, tracker.frames_good, tracker.folds,
                 tracker.frames_bad, tracker.presets);
        $display("Ran %0d register settings, both directions, %0d long output hold-offs",
                 settings_done, holds_done);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
